>>> hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and tables of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] message_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef logic [7:0][31:0] work_type;

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] PAD_LEN_POS = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0:    r = 32'h6a09e667;
         3'd1:    r = 32'hbb67ae85;
         3'd2:    r = 32'h3c6ef372;
         3'd3:    r = 32'ha54ff53a;
         3'd4:    r = 32'h510e527f;
         3'd5:    r = 32'h9b05688c;
         3'd6:    r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
   endfunction

endpackage

>>> hdl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream, block words and chaining hash held in RAM.
// ----------------------------------------------------------------------------
// req channel: one word per item, an optional message byte and an end mark.
// rsp channel: eight digest words, index 0 first, last_word on index 7.
// A byte that does not fill a block and carries no end mark keeps req_ready
// high. The 64th byte of a block starts a compression: loading the schedule
// window and the working registers from the two RAMs, 64 rounds at one per
// cycle and the chaining update, all with req_ready low. The end mark feeds
// padding one byte a cycle, paused for the one or two compressions that it
// needs, then reads the digest out of the hash RAM one word at a time. The
// output register lets the last word wait while the next message already
// streams in. A stalled rsp_ready holds the digest readout. Reset returns
// to the initial hash with an empty block; the hash RAM needs no clearing
// pass, a valid bit per entry stands in for the initial values.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
   import shs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PAD    = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_UPD    = 3'd4;
   localparam logic [2:0] ST_OUT_RD = 3'd5;
   localparam logic [2:0] ST_OUT_LD = 3'd6;

   localparam logic [1:0] P_MARK = 2'd0;
   localparam logic [1:0] P_ZERO = 2'd1;
   localparam logic [1:0] P_LEN  = 2'd2;
   localparam logic [1:0] P_DONE = 2'd3;

   logic [31:0] buf_mem  [16];
   logic [31:0] hash_mem [8];

   logic [2:0]  state_ff, state_in;
   logic [1:0]  pstage_ff, pstage_in;
   logic        pad_ff, pad_in;
   logic [2:0]  lidx_ff, lidx_in;
   logic [5:0]  fill_ff, fill_in;
   logic [23:0] acc_ff, acc_in;
   logic [63:0] len_ff, len_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [7:0]  hvalid_ff, hvalid_in;
   work_type    v_ff, v_in;
   logic [15:0][31:0] w_ff, w_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [31:0] buf_rd_ff;
   logic [31:0] hash_rd_ff;
   logic        hash_rd_ok_ff;
   logic [2:0]  hash_rd_idx_ff;
   logic [31:0] hash_q;

   logic        put_en;
   logic [7:0]  put_byte;
   logic        buf_we;
   logic [31:0] buf_wdata;
   logic        buf_re;
   logic [3:0]  buf_raddr;
   logic        hash_we;
   logic [2:0]  hash_waddr;
   logic [31:0] hash_wdata;
   logic        hash_re;
   logic [2:0]  hash_raddr;
   logic [5:0]  len_sel;
   logic        block_full;

   work_type    v_round;
   logic [31:0] w_new;

   shs_round u_round (
      .v      (v_ff),
      .w0     (w_ff[0]),
      .w1     (w_ff[1]),
      .w9     (w_ff[9]),
      .w14    (w_ff[14]),
      .t      (rnd_ff),
      .v_next (v_round),
      .w_new  (w_new)
   );

   assign hash_q    = hash_rd_ok_ff ? hash_rd_ff : init_hash(hash_rd_idx_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign len_sel   = {3'd7 - lidx_ff, 3'b000};
   assign block_full = put_en && (fill_ff == 6'd63);

   always_comb begin
      state_in     = state_ff;
      pstage_in    = pstage_ff;
      pad_in       = pad_ff;
      lidx_in      = lidx_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      rnd_in       = rnd_ff;
      hvalid_in    = hvalid_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      put_en       = 1'b0;
      put_byte     = 8'h00;
      buf_re       = 1'b0;
      buf_raddr    = cnt_ff[3:0];
      hash_re      = 1'b0;
      hash_raddr   = cnt_ff[2:0];
      hash_we      = 1'b0;
      hash_waddr   = 3'(cnt_ff - 5'd1);
      hash_wdata   = hash_q + v_ff[0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               put_en    = req_data.has_byte;
               put_byte  = req_data.message_byte;
               if (req_data.has_byte) begin
                  len_in = len_ff + 64'd8;
               end
               pad_in    = req_data.end_of_message;
               pstage_in = P_MARK;
               lidx_in   = 3'd0;
               if (block_full) begin
                  state_in = ST_LOAD;
                  cnt_in   = 5'd0;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            case (pstage_ff)
               P_MARK: begin
                  put_en    = 1'b1;
                  put_byte  = PAD_MARK;
                  pstage_in = P_ZERO;
               end
               P_ZERO: begin
                  if (fill_ff == PAD_LEN_POS) begin
                     pstage_in = P_LEN;
                  end else begin
                     put_en = 1'b1;
                  end
               end
               P_LEN: begin
                  put_en   = 1'b1;
                  put_byte = len_ff[len_sel +: 8];
                  lidx_in  = lidx_ff + 3'd1;
                  if (lidx_ff == 3'd7) begin
                     pstage_in = P_DONE;
                  end
               end
               default: ;
            endcase
            if (block_full) begin
               state_in = ST_LOAD;
               cnt_in   = 5'd0;
            end
         end
         ST_LOAD: begin
            buf_re  = !cnt_ff[4];
            hash_re = (cnt_ff < 5'd8);
            if (cnt_ff != 5'd0) begin
               w_in = {buf_rd_ff, w_ff[15:1]};
               if (cnt_ff <= 5'd8) begin
                  v_in = {hash_q, v_ff[7:1]};
               end
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               state_in = ST_ROUND;
               rnd_in   = 6'd0;
            end
         end
         ST_ROUND: begin
            v_in   = v_round;
            w_in   = {w_new, w_ff[15:1]};
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_UPD;
               cnt_in   = 5'd0;
            end
         end
         ST_UPD: begin
            hash_re = (cnt_ff < 5'd8);
            if (cnt_ff != 5'd0) begin
               hash_we             = 1'b1;
               hvalid_in[hash_waddr] = 1'b1;
               v_in                = {v_ff[0], v_ff[7:1]};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd8) begin
               cnt_in = 5'd0;
               if (!pad_ff) begin
                  state_in = ST_IDLE;
               end else if (pstage_ff == P_DONE) begin
                  state_in = ST_OUT_RD;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_OUT_RD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               hash_re  = 1'b1;
               state_in = ST_OUT_LD;
            end
         end
         ST_OUT_LD: begin
            rsp_valid_in       = 1'b1;
            rsp_in.digest_word = hash_q;
            rsp_in.word_index  = cnt_ff[2:0];
            rsp_in.last_word   = (cnt_ff[2:0] == 3'd7);
            cnt_in             = cnt_ff + 5'd1;
            if (cnt_ff[2:0] == 3'd7) begin
               state_in  = ST_IDLE;
               pad_in    = 1'b0;
               hvalid_in = '0;
               len_in    = '0;
               cnt_in    = 5'd0;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      fill_in   = put_en ? fill_ff + 6'd1 : fill_ff;
      acc_in    = put_en ? {acc_ff[15:0], put_byte} : acc_ff;
      buf_we    = put_en && (fill_ff[1:0] == 2'd3);
      buf_wdata = {acc_ff, put_byte};
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[fill_ff[5:2]] <= buf_wdata;
      end
      if (buf_re) begin
         buf_rd_ff <= buf_mem[buf_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (hash_we) begin
         hash_mem[hash_waddr] <= hash_wdata;
      end
      if (hash_re) begin
         hash_rd_ff     <= hash_mem[hash_raddr];
         hash_rd_ok_ff  <= hvalid_ff[hash_raddr];
         hash_rd_idx_ff <= hash_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pstage_ff    <= P_MARK;
         pad_ff       <= 1'b0;
         lidx_ff      <= 3'd0;
         fill_ff      <= 6'd0;
         len_ff       <= '0;
         cnt_ff       <= 5'd0;
         rnd_ff       <= 6'd0;
         hvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pstage_ff    <= pstage_in;
         pad_ff       <= pad_in;
         lidx_ff      <= lidx_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         rnd_ff       <= rnd_in;
         hvalid_ff    <= hvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      v_ff   <= v_in;
      w_ff   <= w_in;
      rsp_ff <= rsp_in;
   end

endmodule

>>> hdl/shs_round.sv
// ----------------------------------------------------------------------------
// shs_round
// One SHA-256 compression round and the next schedule word.
// ----------------------------------------------------------------------------
module shs_round
   import shs_pkg::*;
(
   input  work_type    v,
   input  logic [31:0] w0,
   input  logic [31:0] w1,
   input  logic [31:0] w9,
   input  logic [31:0] w14,
   input  logic [5:0]  t,
   output work_type    v_next,
   output logic [31:0] w_new
);

   logic [31:0] s0, s1, ch, maj, t1, t2, ws0, ws1;

   always_comb begin
      s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + s1 + ch + round_k(t) + w0;
      s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2  = s0 + maj;
      v_next[7] = v[6];
      v_next[6] = v[5];
      v_next[5] = v[4];
      v_next[4] = v[3] + t1;
      v_next[3] = v[2];
      v_next[2] = v[1];
      v_next[1] = v[0];
      v_next[0] = t1 + t2;
      ws0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
      ws1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
      w_new = ws1 + w9 + ws0 + w0;
   end

endmodule
